// ===== rtl/char_sequence_edit_buffer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the character sequence edit buffer
// Shorthand for clocked assertions that are disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef CHAR_SEQUENCE_EDIT_BUFFER_ASSERT_SVH
`define CHAR_SEQUENCE_EDIT_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CEB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edit buffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define CEB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edit buffer check failed");

`endif

// ===== rtl/ceb_pkg.sv =====
// ---------------------------------------------------------------------------
// Edit buffer package
// Sizes, command codes, cell operations and item types shared by the RTL.
// ---------------------------------------------------------------------------
package ceb_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int POS_W = 7;
	localparam int CMD_W = 2;
	localparam int OP_W  = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

	localparam logic [OP_W-1:0] CELL_HOLD = 2'd0;
	localparam logic [OP_W-1:0] CELL_INS  = 2'd1;
	localparam logic [OP_W-1:0] CELL_DEL  = 2'd2;
	localparam logic [OP_W-1:0] CELL_ROT  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [7:0]       ch_in;
		logic [POS_W-1:0] position;
	} req_item_t;

	typedef struct packed {
		logic [7:0] ch_out;
		logic       is_last;
		logic       is_empty;
	} rsp_item_t;

	// Broadcast to every cell of the chain in each cycle.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [7:0]       ch;
	} cell_ctrl_t;

endpackage

// ===== rtl/char_sequence_edit_buffer.sv =====
// ---------------------------------------------------------------------------
// Character sequence edit buffer
// Ordered byte list with append, insert, delete and read-out commands.
// ---------------------------------------------------------------------------
// Usage:
// Command items arrive on req (valid/ready); result items leave on rsp
// (valid/ready). The sequence lives in a chain of DEPTH cells, one byte each.
// Append and insert complete in the cycle that accepts them: every cell past
// the insert point takes its left neighbor's byte and the cell at the point
// takes the new byte. They produce no result item. A full store drops them.
// Delete shifts the tail one cell to the left in the cycle that accepts it,
// then runs a read-out. A read-out rotates the whole chain left by one cell
// per cycle, unless the receiver stalls while bytes remain to be emitted,
// and emits the front cell's byte for each stored byte, so after DEPTH
// rotations the chain is back in order. A read-out or a delete therefore
// holds the request channel until all DEPTH rotations are done, a number set
// by the length of the cell chain; an empty sequence gives a single item
// flagged empty. Each result is registered from the read state.
// A one-entry output register holds the current result item. While the
// receiver stalls, rotation of stored bytes pauses; new commands are taken
// as soon as the rotation has finished, even if the last result still waits.
// Reset clears the length and the control state; cell contents stay as they are.
// ---------------------------------------------------------------------------
`include "char_sequence_edit_buffer_assert.svh"

module char_sequence_edit_buffer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ceb_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ceb_pkg::rsp_item_t rsp
);
	import ceb_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic             state_q, state_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;
	cell_ctrl_t       ctrl;
	logic [7:0]       cell_data [DEPTH];
	logic             accept;
	logic             append_ok;
	logic             out_free;
	logic             emit;
	logic             emit_empty;
	logic [POS_W-1:0] len_pos;
	logic [POS_W-1:0] ins_pos;
	logic [LEN_W-1:0] cnt_inc;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign append_ok = accept && req.cmd == CMD_APPEND && len_q < LEN_W'(DEPTH);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign len_pos   = POS_W'(len_q);
	// An insert point past the end of the sequence becomes an append.
	assign ins_pos   = (req.position > len_pos) ? len_pos : req.position;
	assign cnt_inc   = cnt_q + LEN_W'(1);

	// Command decode and read-out sequencing.
	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		emit       = 1'b0;
		emit_empty = 1'b0;
		ctrl.op    = CELL_HOLD;
		ctrl.pos   = ins_pos;
		ctrl.ch    = req.ch_in;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.cmd)
						CMD_APPEND, CMD_INSERT: begin
							if (len_q < LEN_W'(DEPTH)) begin
								ctrl.op  = CELL_INS;
								ctrl.pos = (req.cmd == CMD_APPEND) ? len_pos : ins_pos;
								len_d    = len_q + LEN_W'(1);
							end
						end
						CMD_DELETE: begin
							if (req.position < len_pos) begin
								ctrl.op  = CELL_DEL;
								ctrl.pos = req.position;
								len_d    = len_q - LEN_W'(1);
							end
							state_d = S_READ;
						end
						default: begin
							state_d = S_READ;
						end
					endcase
				end
			end
			S_READ: begin
				if (len_q == '0) begin
					if (out_free) begin
						emit       = 1'b1;
						emit_empty = 1'b1;
						state_d    = S_IDLE;
					end
				end else if (cnt_q >= len_q || out_free) begin
					// Bytes past the end rotate through without a result.
					emit    = (cnt_q < len_q);
					ctrl.op = CELL_ROT;
					cnt_d   = cnt_inc;
					if (cnt_inc == LEN_W'(DEPTH)) begin
						cnt_d   = '0;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: the front cell, or an empty marker.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.ch_out   <= emit_empty ? 8'd0 : cell_data[0];
			rsp_q.is_last  <= emit_empty || (cnt_inc == len_q);
			rsp_q.is_empty <= emit_empty;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The cell chain. The last cell's right neighbor is the front cell, which
	// closes the ring used for rotation.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ceb_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.idx   (IDX_W'(i)),
			.left  ((i == 0) ? req.ch_in : cell_data[(i + DEPTH - 1) % DEPTH]),
			.right (cell_data[(i + 1) % DEPTH]),
			.data  (cell_data[i])
		);
	end

	`CEB_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_W'(DEPTH))
	`CEB_ASSERT_NOW(a_cnt_bound, state_q == S_READ, cnt_q < LEN_W'(DEPTH))
	`CEB_ASSERT_NEXT(a_append_grows, append_ok, len_q == $past(len_q) + LEN_W'(1))
	`CEB_ASSERT_NOW(a_idle_count, state_q == S_IDLE, cnt_q == '0)

endmodule

// ===== rtl/ceb_cell.sv =====
// ---------------------------------------------------------------------------
// Edit buffer cell
// Holds one byte of the sequence and trades it with its two neighbors.
// ---------------------------------------------------------------------------
module ceb_cell (
	input  logic                    clk,
	input  ceb_pkg::cell_ctrl_t     ctrl,
	input  logic [ceb_pkg::IDX_W-1:0] idx,
	input  logic [7:0]              left,
	input  logic [7:0]              right,
	output logic [7:0]              data
);
	import ceb_pkg::*;

	logic [7:0]       data_q;
	logic [POS_W-1:0] idx_ext;

	assign idx_ext = POS_W'(idx);
	assign data    = data_q;

	// Payload only: contents are undefined until written.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INS: begin
				if (idx_ext == ctrl.pos) begin
					data_q <= ctrl.ch;
				end else if (idx_ext > ctrl.pos) begin
					data_q <= left;
				end
			end
			CELL_DEL: begin
				if (idx_ext >= ctrl.pos) begin
					data_q <= right;
				end
			end
			CELL_ROT: begin
				data_q <= right;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== test/tb_char_sequence_edit_buffer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the character sequence edit buffer
// Drives append, insert, delete and read-out commands through the request
// channel. A shadow copy of the byte sequence predicts every read-out, and
// each result item is checked against it. The sender idles in bursts and the
// receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_char_sequence_edit_buffer;
	import ceb_pkg::*;

	// Clock and reset. Every input of the block has a known value from time zero.
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       rsp_ready = 1'b0;
	req_item_t  req       = '0;
	logic       req_ready;
	logic       rsp_valid;
	rsp_item_t  rsp;

	always #6 clk = ~clk;

	char_sequence_edit_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Shadow of the stored sequence, front first, and the result items that
	// the accepted commands still owe, oldest first.
	logic [7:0] shadow_seq[$];
	rsp_item_t  pending_bytes[$];

	int error_count    = 0;
	int results_seen   = 0;
	int cmd_count[4]   = '{default: 0};
	int full_drops     = 0;
	int longest_seq    = 0;

	// Sender burst state: items left in the current burst.
	int burst_left = 0;

	// Receiver stall pattern state.
	int stall_mode = 0;
	int stall_left = 0;
	int rx_cycle   = 0;

	rsp_item_t want_item;

	// One line per mismatch, and the count that decides the verdict.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Queue up the whole sequence as the block should emit it. An empty
	// sequence still answers with a single item that carries the empty flag.
	function automatic void queue_read_out();
		rsp_item_t r;
		if (shadow_seq.size() == 0) begin
			r.ch_out   = 8'h00;
			r.is_last  = 1'b1;
			r.is_empty = 1'b1;
			pending_bytes.push_back(r);
		end else begin
			for (int i = 0; i < shadow_seq.size(); i++) begin
				r.ch_out   = shadow_seq[i];
				r.is_last  = (i == shadow_seq.size() - 1);
				r.is_empty = 1'b0;
				pending_bytes.push_back(r);
			end
		end
	endfunction

	// Apply one accepted command to the shadow sequence.
	function automatic void apply_edit(input req_item_t it);
		int p;
		p = int'(it.position);
		cmd_count[it.cmd]++;
		case (it.cmd)
			CMD_APPEND, CMD_INSERT: begin
				// Append is an insert at the current end. Anything past the end
				// lands at the end, and a full store drops the byte.
				if (it.cmd == CMD_APPEND || p > shadow_seq.size())
					p = shadow_seq.size();
				if (shadow_seq.size() >= DEPTH)
					full_drops++;
				else
					shadow_seq.insert(p, it.ch_in);
			end
			CMD_DELETE: begin
				// A position at or past the end leaves the sequence alone, but the
				// read-out still follows.
				if (p < shadow_seq.size())
					shadow_seq.delete(p);
				queue_read_out();
			end
			default: begin
				queue_read_out();
			end
		endcase
		if (shadow_seq.size() > longest_seq)
			longest_seq = shadow_seq.size();
	endfunction

	function automatic req_item_t make_cmd(input logic [CMD_W-1:0] c, input logic [7:0] ch,
			input logic [POS_W-1:0] p);
		req_item_t it;
		it.cmd      = c;
		it.ch_in    = ch;
		it.position = p;
		return it;
	endfunction

	// Send one item. At the start of a burst the sender may first drop valid
	// for a random gap; inside a burst valid stays high from item to item.
	// The shadow is updated at the edge where the item is taken.
	task automatic send_cmd(input req_item_t it);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			// About one burst in four starts without any gap at all.
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		apply_edit(it);
	endtask

	// Stop sending and hold off until the block has delivered every result
	// that the accepted items owe.
	task automatic wait_for_results();
		@(negedge clk);
		req_valid  <= 1'b0;
		burst_left = 0;
		while (pending_bytes.size() != 0) @(posedge clk);
	endtask

	// Receiver: the stall pattern is redrawn at random, periodically, from always
	// ready, random stalls, a fixed 4-of-7 duty cycle and rare long stalls.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else begin
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= ($urandom_range(0, 99) >= 30);
				2: rsp_ready <= ((rx_cycle % 7) < 4);
				default: begin
					if ($urandom_range(0, 19) == 0) begin
						stall_left = $urandom_range(3, 12);
						rsp_ready <= 1'b0;
					end else begin
						rsp_ready <= 1'b1;
					end
				end
			endcase
		end
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			stall_mode = $urandom_range(0, 3);
	end

	// Checker: every result item taken is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("result item with nothing owed", int'(rsp), 0);
			end else begin
				want_item = pending_bytes.pop_front();
				results_seen++;
				if (rsp.ch_out !== want_item.ch_out)
					report_mismatch("ch_out", int'(rsp.ch_out), int'(want_item.ch_out));
				if (rsp.is_last !== want_item.is_last)
					report_mismatch("is_last", int'(rsp.is_last), int'(want_item.is_last));
				if (rsp.is_empty !== want_item.is_empty)
					report_mismatch("is_empty", int'(rsp.is_empty),
						int'(want_item.is_empty));
			end
		end
	end

	// An empty sequence: read-out and deletes both answer with the empty item,
	// including a delete at the highest position the field can carry.
	task automatic test_empty_sequence();
		send_cmd(make_cmd(CMD_READ,   8'h00, 7'd0));
		send_cmd(make_cmd(CMD_DELETE, 8'hFF, 7'd0));
		send_cmd(make_cmd(CMD_DELETE, 8'h00, 7'd127));
	endtask

	// Hand-picked edits: byte extremes, insert at the front, past the end, in
	// the middle and exactly at the end, then deletes at the front, exactly at
	// the end, far past the end and of the last byte, down to empty again.
	task automatic test_edit_commands();
		send_cmd(make_cmd(CMD_APPEND, 8'h00, 7'd127));
		send_cmd(make_cmd(CMD_APPEND, 8'hFF, 7'd0));
		send_cmd(make_cmd(CMD_INSERT, 8'hA5, 7'd0));
		send_cmd(make_cmd(CMD_INSERT, 8'h5A, 7'd127));
		send_cmd(make_cmd(CMD_INSERT, 8'h3C, 7'd2));
		send_cmd(make_cmd(CMD_INSERT, 8'h81, 7'd5));
		send_cmd(make_cmd(CMD_READ,   8'hFF, 7'd127));
		send_cmd(make_cmd(CMD_DELETE, 8'h00, 7'd0));
		send_cmd(make_cmd(CMD_DELETE, 8'h00, 7'd5));
		send_cmd(make_cmd(CMD_DELETE, 8'h00, 7'd64));
		send_cmd(make_cmd(CMD_DELETE, 8'h00, 7'd4));
		send_cmd(make_cmd(CMD_READ,   8'h00, 7'd0));
		repeat (4) send_cmd(make_cmd(CMD_DELETE, 8'h00, 7'd0));
	endtask

	// Fill the store to DEPTH with random appends and inserts, then try to add
	// more in every way, which must all be dropped, and read the full store.
	// A delete and a refill check that space frees up again.
	task automatic test_full_store();
		while (shadow_seq.size() < DEPTH) begin
			if ($urandom_range(0, 1) == 0)
				send_cmd(make_cmd(CMD_APPEND, 8'($urandom_range(0, 255)),
					7'($urandom_range(0, 127))));
			else
				send_cmd(make_cmd(CMD_INSERT, 8'($urandom_range(0, 255)),
					POS_W'($urandom_range(0, shadow_seq.size()))));
		end
		send_cmd(make_cmd(CMD_APPEND, 8'hEE, 7'd0));
		send_cmd(make_cmd(CMD_INSERT, 8'h11, 7'd0));
		send_cmd(make_cmd(CMD_INSERT, 8'h22, 7'd127));
		send_cmd(make_cmd(CMD_READ,   8'h00, 7'd0));
		send_cmd(make_cmd(CMD_DELETE, 8'h00, POS_W'(DEPTH - 1)));
		send_cmd(make_cmd(CMD_INSERT, 8'h77, 7'd0));
		send_cmd(make_cmd(CMD_READ,   8'h00, 7'd0));
	endtask

	// Random edits in phases that grow, shrink or churn the sequence, so the
	// length sweeps its whole range. Positions mostly fall within or just at
	// the end of the sequence; one in ten is drawn from the full field.
	function automatic req_item_t random_edit(input int phase);
		int roll;
		int len;
		logic [CMD_W-1:0] c;
		logic [POS_W-1:0] p;
		len  = shadow_seq.size();
		roll = $urandom_range(0, 99);
		case (phase)
			0: c = (roll < 45) ? CMD_APPEND : (roll < 80) ? CMD_INSERT :
				(roll < 90) ? CMD_DELETE : CMD_READ;
			1: c = (roll < 10) ? CMD_APPEND : (roll < 20) ? CMD_INSERT :
				(roll < 75) ? CMD_DELETE : CMD_READ;
			default: c = (roll < 25) ? CMD_APPEND : (roll < 50) ? CMD_INSERT :
				(roll < 75) ? CMD_DELETE : CMD_READ;
		endcase
		if ($urandom_range(0, 9) == 0)
			p = 7'($urandom_range(0, 127));
		else
			p = POS_W'($urandom_range(0, len));
		return make_cmd(c, 8'($urandom_range(0, 255)), p);
	endfunction

	task automatic test_random_edits(input int n_items);
		int sent;
		int phase;
		int phase_len;
		sent = 0;
		while (sent < n_items) begin
			phase     = $urandom_range(0, 2);
			phase_len = $urandom_range(10, 50);
			for (int i = 0; i < phase_len && sent < n_items; i++) begin
				send_cmd(random_edit(phase));
				sent++;
				// Now and then let the block run completely dry mid-stream.
				if (sent % 100 == 0)
					wait_for_results();
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_sequence();
		test_edit_commands();
		wait_for_results();
		test_full_store();
		wait_for_results();
		test_random_edits(370);

		// Everything sent: wait for the owed results, then give the block a
		// full read-out's worth of cycles to show any stray item.
		wait_for_results();
		repeat (DEPTH + 8) @(posedge clk);

		$display("Sent %0d appends, %0d inserts, %0d deletes, %0d read-outs;",
			cmd_count[CMD_APPEND], cmd_count[CMD_INSERT], cmd_count[CMD_DELETE],
			cmd_count[CMD_READ]);
		$display("%0d dropped on a full store; checked %0d result items; longest %0d bytes.",
			full_drops, results_seen, longest_seq);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog. The slowest correct run is about 460 items of 64 results, each
	// result held up by receiver stalls, plus sender gaps. The limit leaves
	// several times that.
	initial begin
		#30_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ceb_pkg.sv
rtl/ceb_cell.sv
rtl/char_sequence_edit_buffer.sv
test/tb_char_sequence_edit_buffer.sv
